@@ rtl/core/fau_pkg.sv @@
`timescale 1ns / 1ps

package fau_pkg;

  localparam int IN_W    = 16;
  localparam int ACT_W   = 3;
  localparam int RES_W   = 32;

  typedef logic        [RES_W-1:0] word_t;
  typedef logic signed [RES_W-1:0] sword_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 3'd0,
    ACT_MUL = 3'd1,
    ACT_CMP = 3'd2,
    ACT_INC = 3'd3,
    ACT_RED = 3'd4
  } fau_action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_RED,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_NEXT,
    S_OUT
  } fau_state_e;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } fau_div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } fau_div_rsp_t;

endpackage

@@ rtl/core/fau_in_if.sv @@
`timescale 1ns / 1ps

interface fau_in_if
  import fau_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic        [ACT_W-1:0] action;
  logic signed [IN_W-1:0]  a_num;
  logic signed [IN_W-1:0]  a_den;
  logic signed [IN_W-1:0]  b_num;
  logic signed [IN_W-1:0]  b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ rtl/core/fau_out_if.sv @@
`timescale 1ns / 1ps

interface fau_out_if
  import fau_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_num;
  logic signed [RES_W-1:0] res_den;
  logic                    is_equal;
  logic                    div_error;

  modport source (output valid, res_num, res_den, is_equal, div_error, input ready);
  modport sink   (input valid, res_num, res_den, is_equal, div_error, output ready);
endinterface

@@ rtl/core/fau_mul.sv @@
`timescale 1ns / 1ps

module fau_mul
  import fau_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   x_i,
  input  logic signed [W-1:0]   y_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= x_i * y_i;
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/fau_gcd.sv @@
`timescale 1ns / 1ps

module fau_gcd
  import fau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t x_i,
  input  word_t y_i,
  output logic  done_o,
  output word_t g_o
);

  localparam int KW = $clog2(RES_W);

  word_t         x_q, x_d, y_q, y_d, g_q, g_d;
  logic [KW-1:0] k_q, k_d;
  logic          run_q, run_d, done_q, done_d;

  // binary gcd, one shift or subtract per cycle
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d   = x_i;
      y_d   = y_i;
      k_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (x_q == '0 || y_q == '0) begin
        g_d    = (x_q | y_q) << k_q;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q >= y_q) begin
        x_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

@@ rtl/core/fau_div.sv @@
`timescale 1ns / 1ps

module fau_div
  import fau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fau_div_req_t req_i,
  output fau_div_rsp_t rsp_o
);

  localparam int CW = $clog2(RES_W);

  logic [RES_W:0]  rem_sh;
  word_t           rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[RES_W-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = RES_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[RES_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[RES_W-1:0];
        quo_d = {quo_q[RES_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(RES_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ rtl/core/fraction_arithmetic_unit.sv @@
`timescale 1ns / 1ps

// Fraction unit: add, multiply, equality compare, increment or reduce of
// 16-bit fractions, one item at a time. Results with positive numerator and
// denominator are reduced by their gcd. A small sequencer drives one
// registered multiplier (up to three products), a binary gcd engine (one
// shift or subtract per cycle) and a one-bit-per-cycle divider (run once
// for the numerator and once for the denominator); compare reduces two
// fractions. in_i.ready is high only while the sequencer is idle; a
// finished item waits in the output register while the next one is taken.
module fraction_arithmetic_unit
  import fau_pkg::*;
#(
  parameter int OPERAND_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fau_in_if.sink    in_i,
  fau_out_if.source out_o
);

  localparam int OB = OPERAND_BITS;

  fau_state_e state_q, state_d;

  logic [ACT_W-1:0]     act_q, act_d;
  logic signed [OB-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  sword_t               fn_q, fn_d, fd_q, fd_d, sn_q, sn_d, sd_q, sd_d;
  word_t                g_q, g_d;
  logic                 pass_q, pass_d, err_q, err_d;
  sword_t               rn_q, rn_d, rd_q, rd_d;
  logic                 eq_q, eq_d, er_q, er_d, ov_q, ov_d;

  logic signed [OB-1:0]   mul_x, mul_y;
  logic signed [2*OB-1:0] mul_p;
  sword_t                 prod;
  logic signed [OB:0]     inc_sum;
  logic                   gcd_start, gcd_done;
  word_t                  gcd_g;
  fau_div_req_t           div_req;
  fau_div_rsp_t           div_rsp;
  logic                   is_add, fn_pos, fd_pos;

  fau_mul #(.W(OB)) u_mul (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .p_o   (mul_p)
  );

  fau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (word_t'(fn_q)),
    .y_i     (word_t'(fd_q)),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  fau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign is_add  = (act_q == ACT_ADD);
  assign prod    = RES_W'(mul_p);
  assign inc_sum = (OB+1)'(an_q) + (OB+1)'(ad_q);
  assign fn_pos  = !fn_q[RES_W-1] && (fn_q != '0);
  assign fd_pos  = !fd_q[RES_W-1] && (fd_q != '0);

  always_comb begin
    case (state_q)
      S_M1: begin
        mul_x = is_add ? bn_q : ad_q;
        mul_y = is_add ? ad_q : bd_q;
      end
      S_M2: begin
        mul_x = ad_q;
        mul_y = bd_q;
      end
      default: begin
        mul_x = an_q;
        mul_y = is_add ? bd_q : bn_q;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    an_d          = an_q;
    ad_d          = ad_q;
    bn_d          = bn_q;
    bd_d          = bd_q;
    fn_d          = fn_q;
    fd_d          = fd_q;
    sn_d          = sn_q;
    sd_d          = sd_q;
    g_d           = g_q;
    pass_d        = pass_q;
    err_d         = err_q;
    rn_d          = rn_q;
    rd_d          = rd_q;
    eq_d          = eq_q;
    er_d          = er_q;
    ov_d          = ov_q && !out_o.ready;
    gcd_start     = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = (state_q == S_GCD) ? word_t'(fn_q) : word_t'(fd_q);
    div_req.den   = (state_q == S_GCD) ? gcd_g : g_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          an_d    = in_i.a_num[OB-1:0];
          ad_d    = in_i.a_den[OB-1:0];
          bn_d    = in_i.b_num[OB-1:0];
          bd_d    = in_i.b_den[OB-1:0];
          err_d   = 1'b0;
          pass_d  = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        case (act_q)
          ACT_ADD: begin
            if (ad_q == '0 || bd_q == '0) begin
              err_d   = 1'b1;
              fn_d    = '0;
              fd_d    = '0;
              state_d = S_RED;
            end else begin
              state_d = S_M0;
            end
          end
          ACT_MUL: state_d = S_M0;
          ACT_CMP, ACT_RED: begin
            fn_d    = RES_W'(an_q);
            fd_d    = RES_W'(ad_q);
            state_d = S_RED;
          end
          ACT_INC: begin
            fn_d    = RES_W'(inc_sum);
            fd_d    = RES_W'(ad_q);
            state_d = S_RED;
          end
          default: begin
            fn_d    = '0;
            fd_d    = '0;
            state_d = S_RED;
          end
        endcase
      end
      S_M0: state_d = S_M1;
      S_M1: begin
        fn_d    = prod;
        state_d = S_M2;
      end
      S_M2: begin
        if (is_add) begin
          fn_d    = fn_q + prod;
          state_d = S_M3;
        end else begin
          fd_d    = prod;
          state_d = S_RED;
        end
      end
      S_M3: begin
        fd_d    = prod;
        state_d = S_RED;
      end
      S_RED: begin
        if (fn_pos && fd_pos) begin
          gcd_start = 1'b1;
          state_d   = S_GCD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          g_d           = gcd_g;
          div_req.start = 1'b1;
          state_d       = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          fn_d          = sword_t'(div_rsp.quo);
          div_req.start = 1'b1;
          state_d       = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          fd_d    = sword_t'(div_rsp.quo);
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (act_q == ACT_CMP && !pass_q) begin
          sn_d    = fn_q;
          sd_d    = fd_q;
          fn_d    = RES_W'(bn_q);
          fd_d    = RES_W'(bd_q);
          pass_d  = 1'b1;
          state_d = S_RED;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          if (act_q == ACT_CMP) begin
            rn_d = '0;
            rd_d = '0;
            eq_d = (sn_q == fn_q) && (sd_q == fd_q);
          end else begin
            rn_d = fn_q;
            rd_d = fd_q;
            eq_d = 1'b0;
          end
          er_d    = err_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      pass_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      pass_q  <= pass_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    fn_q  <= fn_d;
    fd_q  <= fd_d;
    sn_q  <= sn_d;
    sd_q  <= sd_d;
    g_q   <= g_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    eq_q  <= eq_d;
    er_q  <= er_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.res_num   = rn_q;
  assign out_o.res_den   = rd_q;
  assign out_o.is_equal  = eq_q;
  assign out_o.div_error = er_q;

endmodule

@@ tb/fraction_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps

module fraction_arithmetic_unit_tb
  import fau_pkg::*;
();

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 300;
  localparam int ACT_FIRST_UNUSED = int'(ACT_RED) + 1;
  localparam int ACT_LAST_CODE    = (1 << ACT_W) - 1;

  localparam logic signed [IN_W-1:0] OP_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] OP_MIN = {1'b1, {(IN_W-1){1'b0}}};

  typedef struct packed {
    logic        [ACT_W-1:0] action;
    logic signed [IN_W-1:0]  a_num;
    logic signed [IN_W-1:0]  a_den;
    logic signed [IN_W-1:0]  b_num;
    logic signed [IN_W-1:0]  b_den;
  } frac_item_t;

  typedef struct packed {
    sword_t res_num;
    sword_t res_den;
    logic   is_equal;
    logic   div_error;
  } frac_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fau_in_if  in_if ();
  fau_out_if out_if ();

  fraction_arithmetic_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  frac_item_t   stim_items[$];
  frac_result_t expected_fracs[$];
  frac_item_t   cur_item;
  frac_result_t exp_frac;

  int fail_count     = 0;
  int items_pushed   = 0;
  int items_accepted = 0;
  int src_gap_pct    = 0;
  int snk_stall_pct  = 0;
  int src_gap        = 0;
  int snk_stall      = 0;
  int hold_left      = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int idle_cycles    = 0;

  function automatic longint wrap32(longint v);
    logic signed [RES_W-1:0] w;
    w = v[RES_W-1:0];
    return w;
  endfunction

  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // only fractions with both parts positive are reduced
  function automatic void reduce_frac(inout longint n, inout longint d);
    longint g;
    if (n > 0 && d > 0) begin
      g = gcd_of(n, d);
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic frac_result_t fraction_result(frac_item_t it);
    longint       an, ad, bn, bd, rn, rd;
    frac_result_t r;
    an = $signed(it.a_num);
    ad = $signed(it.a_den);
    bn = $signed(it.b_num);
    bd = $signed(it.b_den);
    rn = 0;
    rd = 0;
    r  = '0;
    case (it.action)
      ACT_ADD: begin
        if (ad == 0 || bd == 0) begin
          r.div_error = 1'b1;
        end else begin
          rn = wrap32(an * bd + bn * ad);
          rd = wrap32(ad * bd);
          reduce_frac(rn, rd);
        end
      end
      ACT_MUL: begin
        rn = wrap32(an * bn);
        rd = wrap32(ad * bd);
        reduce_frac(rn, rd);
      end
      ACT_CMP: begin
        reduce_frac(an, ad);
        reduce_frac(bn, bd);
        r.is_equal = (an == bn) && (ad == bd);
      end
      ACT_INC: begin
        rn = an + ad;
        rd = ad;
        reduce_frac(rn, rd);
      end
      ACT_RED: begin
        rn = an;
        rd = ad;
        reduce_frac(rn, rd);
      end
      default: ;
    endcase
    r.res_num = rn[RES_W-1:0];
    r.res_den = rd[RES_W-1:0];
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_operand(int unsigned f);
    logic signed [IN_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = IN_W'($urandom);
      3, 4, 5, 6: v = IN_W'($urandom_range(1, int'(OP_MAX) / f) * f);
      7: v = IN_W'(-($urandom_range(1, int'(OP_MAX) / f) * f));
      8: begin
        case ($urandom_range(4))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = OP_MAX;
          default: v = OP_MIN;
        endcase
      end
      default: v = IN_W'($urandom_range(1, 20));
    endcase
    return v;
  endfunction

  function automatic frac_item_t random_item();
    frac_item_t  it;
    int unsigned f, p, q, f1, f2;
    f = $urandom_range(1, 200);
    if ($urandom_range(99) < 95) it.action = ACT_W'($urandom_range(int'(ACT_RED)));
    else it.action = ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
    it.a_num = pick_operand(f);
    it.a_den = pick_operand(f);
    it.b_num = pick_operand(f);
    it.b_den = pick_operand(f);
    // equal fractions in different scalings
    if (it.action == ACT_CMP && $urandom_range(1) == 1) begin
      p  = $urandom_range(1, 100);
      q  = $urandom_range(1, 100);
      f1 = $urandom_range(1, int'(OP_MAX) / ((p > q) ? p : q));
      f2 = $urandom_range(1, int'(OP_MAX) / ((p > q) ? p : q));
      it.a_num = IN_W'(p * f1);
      it.a_den = IN_W'(q * f1);
      it.b_num = IN_W'(p * f2);
      it.b_den = IN_W'(q * f2);
    end
    return it;
  endfunction

  task automatic push_item(int act, int an, int ad, int bn, int bd);
    frac_item_t it;
    it.action = ACT_W'(act);
    it.a_num  = IN_W'(an);
    it.a_den  = IN_W'(ad);
    it.b_num  = IN_W'(bn);
    it.b_den  = IN_W'(bd);
    stim_items.push_back(it);
    items_pushed++;
  endtask

  task automatic run_random(int n, int gap_pct, int stall_pct, bit with_hold);
    @(negedge clk_i);
    src_gap_pct   = gap_pct;
    snk_stall_pct = stall_pct;
    if (with_hold) hold_req++;
    repeat (n) begin
      stim_items.push_back(random_item());
      items_pushed++;
    end
    while (items_accepted < items_pushed) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      src_gap     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_fracs.push_back(fraction_result(cur_item));
        items_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          in_if.valid <= 1'b0;
          src_gap     <= src_gap - 1;
        end else if (stim_items.size() > 0) begin
          cur_item      = stim_items.pop_front();
          in_if.action <= cur_item.action;
          in_if.a_num  <= cur_item.a_num;
          in_if.a_den  <= cur_item.a_den;
          in_if.b_num  <= cur_item.b_num;
          in_if.b_den  <= cur_item.b_den;
          in_if.valid  <= 1'b1;
          if ($urandom_range(99) < src_gap_pct) src_gap <= $urandom_range(1, 15);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_stall    <= 0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (snk_stall > 0) begin
      out_if.ready <= 1'b0;
      snk_stall    <= snk_stall - 1;
    end else if ($urandom_range(99) < snk_stall_pct) begin
      out_if.ready <= 1'b0;
      snk_stall    <= $urandom_range(0, 14);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_fracs.size() == 0) begin
        $error("result with nothing expected: num %0d den %0d",
               out_if.res_num, out_if.res_den);
        fail_count++;
      end else begin
        exp_frac = expected_fracs.pop_front();
        if (out_if.res_num !== exp_frac.res_num) begin
          $error("res_num: expected %0d, got %0d", exp_frac.res_num, out_if.res_num);
          fail_count++;
        end
        if (out_if.res_den !== exp_frac.res_den) begin
          $error("res_den: expected %0d, got %0d", exp_frac.res_den, out_if.res_den);
          fail_count++;
        end
        if (out_if.is_equal !== exp_frac.is_equal) begin
          $error("is_equal: expected %0b, got %0b", exp_frac.is_equal, out_if.is_equal);
          fail_count++;
        end
        if (out_if.div_error !== exp_frac.div_error) begin
          $error("div_error: expected %0b, got %0b", exp_frac.div_error, out_if.div_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fraction_arithmetic_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = '0;
    in_if.a_num  = '0;
    in_if.a_den  = '0;
    in_if.b_num  = '0;
    in_if.b_den  = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    src_gap_pct   = 20;
    snk_stall_pct = 20;
    push_item(ACT_ADD, 1, 2, 1, 3);
    push_item(ACT_ADD, 1, 0, 1, 2);
    push_item(ACT_ADD, 1, 2, 5, 0);
    // numerator sum wraps past 32 bits
    push_item(ACT_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    push_item(ACT_ADD, OP_MAX, OP_MAX, OP_MAX, 1);
    push_item(ACT_MUL, 2, 3, 3, 4);
    push_item(ACT_MUL, 5, 0, 3, 7);
    push_item(ACT_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    push_item(ACT_MUL, OP_MAX, -1, OP_MIN, 1);
    push_item(ACT_CMP, 1, 2, 2, 4);
    push_item(ACT_CMP, -1, 2, -2, 4);
    push_item(ACT_CMP, 3, 0, 3, 0);
    push_item(ACT_CMP, OP_MAX, OP_MAX, 1, 1);
    push_item(ACT_INC, 1, 2, 0, 0);
    push_item(ACT_INC, -3, 2, 0, 0);
    push_item(ACT_INC, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    push_item(ACT_INC, OP_MIN, OP_MIN, -1, -1);
    push_item(ACT_RED, 12, 18, 0, 0);
    push_item(ACT_RED, 0, 5, 0, 0);
    push_item(ACT_RED, -4, -8, 7, 9);
    push_item(ACT_RED, OP_MAX, 1, 0, 0);
    push_item(ACT_RED, 1, OP_MIN, 0, 0);
    for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_CODE; a++) begin
      push_item(a, 6, 4, OP_MIN, OP_MAX);
    end
    while (items_accepted < items_pushed) @(negedge clk_i);

    run_random(400, 30, 30, 1'b0);
    run_random(300, 0, 0, 1'b0);
    run_random(300, 10, 50, 1'b1);
    run_random(300, 60, 60, 1'b0);
    run_random(150, 0, 0, 1'b0);

    while (expected_fracs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_fracs.size() != 0) begin
      $error("%0d expected results never arrived", expected_fracs.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("fraction_arithmetic_unit_tb OK");
    end else begin
      $display("fraction_arithmetic_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
